[hw/rtl/grid_unit_disk_cover_core_assert.svh]
// Assertion macros shared by the checker
`ifndef GRID_UNIT_DISK_COVER_CORE_ASSERT_SVH
`define GRID_UNIT_DISK_COVER_CORE_ASSERT_SVH

// same-cycle implication, gated by reset
`define GUDC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gudc assertion failed");

// next-cycle implication, gated by reset
`define GUDC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gudc assertion failed");

`endif

[hw/rtl/gudc_pkg.sv]
// Types and constants of the grid unit disk cover core
`timescale 1ns / 1ps
`default_nettype none
package gudc_pkg;

    localparam int IDX_W   = 12;   // lattice index, grid sides up to 4096
    localparam int COORD_W = 24;
    localparam int CW_W    = 23;
    localparam int INV_W   = 24;
    localparam int RSQ_W   = 48;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 64;

    typedef enum logic [1:0] {
        ST_OWN = 2'd0,
        ST_NBR = 2'd1,
        ST_NEW = 2'd2,
        ST_OUT = 2'd3
    } t_status;

    localparam logic [1:0] REG_CELL_W = 2'd0;
    localparam logic [1:0] REG_INV_W  = 2'd1;
    localparam logic [1:0] REG_RSQ    = 2'd2;
    localparam logic [1:0] REG_HEIGHT = 2'd3;

    typedef struct packed {
        logic [CW_W-1:0]           cell_width;
        logic [INV_W-1:0]          inv_cell_width;
        logic [RSQ_W-1:0]          rsq_limit;
        logic signed [COORD_W-1:0] disk_height;
    } t_cfg;

    typedef struct packed {
        logic                      mode;
        logic                      outside;
        logic [IDX_W-1:0]          col;
        logic [IDX_W-1:0]          row;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
    } t_cmd;

    typedef struct packed {
        t_status                   status;
        logic [7:0]                col;
        logic [7:0]                row;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
    } t_res;

endpackage
`default_nettype wire

[hw/rtl/gudc_fifo.sv]
// Two-entry queue used between front, back and the result ports
`timescale 1ns / 1ps
`default_nettype none
module gudc_fifo #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_empty
);
    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         w_do_push, w_do_pop;

    assign o_full    = (r_cnt == 2'd2);
    assign o_empty   = (r_cnt == 2'd0);
    assign o_data    = r_mem[r_rp];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_do_push) r_wp <= ~r_wp;
            if (w_do_pop)  r_rp <= ~r_rp;
            if (w_do_push && !w_do_pop)      r_cnt <= r_cnt + 2'd1;
            else if (!w_do_push && w_do_pop) r_cnt <= r_cnt - 2'd1;
        end
    end
endmodule
`default_nettype wire

[hw/rtl/gudc_front.sv]
// Front: maps a point to its lattice cell and flags points off the grid
`timescale 1ns / 1ps
`default_nettype none
module gudc_front #(
    parameter int GRID_COLS = 256,
    parameter int GRID_ROWS = 256
) (
    input  wire logic                                i_mode,
    input  wire logic signed [gudc_pkg::COORD_W-1:0] i_point_x,
    input  wire logic signed [gudc_pkg::COORD_W-1:0] i_point_y,
    input  wire logic [gudc_pkg::INV_W-1:0]          i_inv,
    output gudc_pkg::t_cmd                           o_cmd
);
    logic signed [48:0] w_prod_x, w_prod_y;
    logic               w_out_x, w_out_y;

    // floor(p * inv / 2^16) is the arithmetic shift of the product
    assign w_prod_x = i_point_x * $signed({1'b0, i_inv});
    assign w_prod_y = i_point_y * $signed({1'b0, i_inv});

    assign w_out_x = w_prod_x[48] || (w_prod_x[47:16] >= 32'(GRID_COLS));
    assign w_out_y = w_prod_y[48] || (w_prod_y[47:16] >= 32'(GRID_ROWS));

    always_comb begin
        o_cmd.mode    = i_mode;
        o_cmd.outside = w_out_x || w_out_y;
        o_cmd.col     = w_prod_x[16 +: gudc_pkg::IDX_W];
        o_cmd.row     = w_prod_y[16 +: gudc_pkg::IDX_W];
        o_cmd.px      = i_point_x;
        o_cmd.py      = i_point_y;
    end
endmodule
`default_nettype wire

[hw/rtl/gudc_back.sv]
// Back: occupancy bitmap, neighbor coverage test and disk placement
`timescale 1ns / 1ps
`default_nettype none
module gudc_back #(
    parameter int GRID_COLS = 256,
    parameter int GRID_ROWS = 256
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire gudc_pkg::t_cfg        i_cfg,
    input  wire logic                  i_cmd_valid,
    input  wire gudc_pkg::t_cmd        i_cmd,
    output logic                       o_cmd_pop,
    input  wire logic                  i_res_full,
    output logic                       o_res_push,
    output gudc_pkg::t_res             o_res,
    output logic                       o_init_busy
);
    localparam int CW = $clog2(GRID_COLS);
    localparam int RW = $clog2(GRID_ROWS);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_CLR    = 9'b000000010,
        S_RD_OWN = 9'b000000100,
        S_RD_UP  = 9'b000001000,
        S_RD_DN  = 9'b000010000,
        S_DIFF   = 9'b000100000,
        S_SQ     = 9'b001000000,
        S_CMP    = 9'b010000000,
        S_FIN    = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [GRID_COLS-1:0] r_map [GRID_ROWS];
    logic [GRID_COLS-1:0] r_q, r_own, r_up, r_dn;
    logic [RW-1:0]        r_addr;
    logic                 r_init;
    gudc_pkg::t_cmd       r_cmd;
    logic [35:0]          r_cx, r_cy;
    logic [24:0]          r_adx, r_ady;
    logic [49:0]          r_sqx, r_sqy;
    logic                 r_nocc, r_hit;
    logic [1:0]           r_k;

    logic [CW-1:0]        w_col, w_col_p1, w_col_m1;
    logic [RW-1:0]        w_row, w_row_p1, w_row_m1;
    logic                 w_r_ok, w_l_ok, w_u_ok, w_d_ok;
    logic [RW-1:0]        w_raddr, w_waddr;
    logic [GRID_COLS-1:0] w_wdata;
    logic                 w_we;
    logic signed [37:0]   w_ncx, w_ncy, w_dx, w_dy, w_ax, w_ay, w_cw;
    logic                 w_nocc;
    logic [50:0]          w_dist;
    gudc_pkg::t_status    w_status;

    assign w_col    = r_cmd.col[CW-1:0];
    assign w_row    = r_cmd.row[RW-1:0];
    assign w_col_p1 = w_col + CW'(1);
    assign w_col_m1 = w_col - CW'(1);
    assign w_row_p1 = w_row + RW'(1);
    assign w_row_m1 = w_row - RW'(1);
    assign w_r_ok   = ({1'b0, r_cmd.col} + 13'd1) < 13'(GRID_COLS);
    assign w_l_ok   = (r_cmd.col != '0);
    assign w_u_ok   = (r_cmd.row != '0);
    assign w_d_ok   = ({1'b0, r_cmd.row} + 13'd1) < 13'(GRID_ROWS);

    // neighbor order: right, left, up (row - 1), down (row + 1)
    assign w_cw = $signed(38'(i_cfg.cell_width));
    always_comb begin
        w_ncx  = $signed({2'b00, r_cx});
        w_ncy  = $signed({2'b00, r_cy});
        w_nocc = 1'b0;
        case (r_k)
            2'd0: begin
                w_ncx  = $signed({2'b00, r_cx}) + w_cw;
                w_nocc = w_r_ok && r_own[w_col_p1];
            end
            2'd1: begin
                w_ncx  = $signed({2'b00, r_cx}) - w_cw;
                w_nocc = w_l_ok && r_own[w_col_m1];
            end
            2'd2: begin
                w_ncy  = $signed({2'b00, r_cy}) - w_cw;
                w_nocc = w_u_ok && r_up[w_col];
            end
            default: begin
                w_ncy  = $signed({2'b00, r_cy}) + w_cw;
                w_nocc = w_d_ok && r_dn[w_col];
            end
        endcase
    end

    assign w_dx   = 38'(r_cmd.px) - w_ncx;
    assign w_dy   = 38'(r_cmd.py) - w_ncy;
    assign w_ax   = w_dx[37] ? -w_dx : w_dx;
    assign w_ay   = w_dy[37] ? -w_dy : w_dy;
    assign w_dist = 51'(r_sqx) + 51'(r_sqy);

    always_comb begin
        if (r_cmd.outside)    w_status = gudc_pkg::ST_OUT;
        else if (r_own[w_col]) w_status = gudc_pkg::ST_OWN;
        else if (r_hit)       w_status = gudc_pkg::ST_NBR;
        else                  w_status = gudc_pkg::ST_NEW;
    end

    always_comb begin
        o_res = '0;
        o_res.status = w_status;
        if (w_status != gudc_pkg::ST_OUT) begin
            o_res.col = r_cmd.col[7:0];
            o_res.row = r_cmd.row[7:0];
        end
        if (w_status == gudc_pkg::ST_NEW) begin
            o_res.cx = (r_cx > 36'd8388607) ? 24'sh7FFFFF : $signed(r_cx[23:0]);
            o_res.cy = (r_cy > 36'd8388607) ? 24'sh7FFFFF : $signed(r_cy[23:0]);
            o_res.cz = i_cfg.disk_height;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        w_raddr    = w_row;
        case (r_state)
            S_IDLE: begin
                w_raddr   = i_cmd.row[RW-1:0];
                o_cmd_pop = i_cmd_valid;
                if (i_cmd_valid) begin
                    if (i_cmd.mode)         n_state = S_CLR;
                    else if (i_cmd.outside) n_state = S_FIN;
                    else                    n_state = S_RD_OWN;
                end
            end
            S_CLR:    if (r_addr == RW'(GRID_ROWS - 1)) n_state = S_IDLE;
            S_RD_OWN: begin
                w_raddr = w_row_m1;
                n_state = S_RD_UP;
            end
            S_RD_UP: begin
                w_raddr = w_d_ok ? w_row_p1 : w_row;
                n_state = S_RD_DN;
            end
            S_RD_DN:  n_state = S_DIFF;
            S_DIFF:   n_state = S_SQ;
            S_SQ:     n_state = S_CMP;
            S_CMP:    n_state = (r_k == 2'd3) ? S_FIN : S_DIFF;
            S_FIN: begin
                o_res_push = !i_res_full;
                if (!i_res_full) n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    assign w_we    = (r_state == S_CLR) ||
                     ((r_state == S_FIN) && !i_res_full && (w_status == gudc_pkg::ST_NEW));
    assign w_waddr = (r_state == S_CLR) ? r_addr : w_row;
    assign w_wdata = (r_state == S_CLR) ? '0 : (r_own | (GRID_COLS'(1) << w_col));

    always_ff @(posedge i_clk) begin
        if (w_we) r_map[w_waddr] <= w_wdata;
        r_q <= r_map[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: if (i_cmd_valid) r_cmd <= i_cmd;
            S_RD_OWN: begin
                r_own <= r_q;
                r_cx  <= 36'(r_cmd.col) * 36'(i_cfg.cell_width)
                         + 36'(i_cfg.cell_width >> 1);
            end
            S_RD_UP: begin
                r_up <= r_q;
                r_cy <= 36'(r_cmd.row) * 36'(i_cfg.cell_width)
                        + 36'(i_cfg.cell_width >> 1);
            end
            S_RD_DN: r_dn <= r_q;
            S_DIFF: begin
                r_adx  <= (w_ax > 38'sd16777216) ? 25'd16777216 : w_ax[24:0];
                r_ady  <= (w_ay > 38'sd16777216) ? 25'd16777216 : w_ay[24:0];
                r_nocc <= w_nocc;
            end
            S_SQ: begin
                r_sqx <= r_adx * r_adx;
                r_sqy <= r_ady * r_ady;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_addr  <= '0;
            r_init  <= 1'b1;
            r_hit   <= 1'b0;
            r_k     <= 2'd0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    r_addr <= '0;
                    r_hit  <= 1'b0;
                    r_k    <= 2'd0;
                end
                S_CLR: begin
                    r_addr <= r_addr + RW'(1);
                    if (r_addr == RW'(GRID_ROWS - 1)) r_init <= 1'b0;
                end
                S_CMP: begin
                    if (r_nocc && (w_dist <= 51'(i_cfg.rsq_limit))) r_hit <= 1'b1;
                    r_k <= r_k + 2'd1;
                end
                default: ;
            endcase
        end
    end

    assign o_init_busy = r_init;
endmodule
`default_nettype wire

[hw/rtl/grid_unit_disk_cover_core.sv]
// Top level of the grid unit disk cover core
//
//  channel   handshake          payload
//  --------  -----------------  ------------------------------------------------
//  input     push / full        i_mode, i_point_x, i_point_y
//  result    pop / empty        o_status, o_cell_col, o_cell_row, o_center_x/y/z
//  config    APB psel/penable   paddr (8-byte stride), pwdata, prdata, pready
//
//  Flow: a point passes the back engine as dequeue, three bitmap row reads,
//  difference/square/compare for each of four neighbors, result push and write.
//  An off-grid point goes from dequeue straight to the result push; a clear item sweeps one row a cycle.
//  Reset is synchronous; after it the bitmap is swept row by row with
//  full held high. Two-entry queues between front and back and at the result
//  side let input and output stall independently.
`timescale 1ns / 1ps
`default_nettype none
module grid_unit_disk_cover_core #(
    parameter int GRID_COLS = 256,
    parameter int GRID_ROWS = 256
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // input item queue side
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic                                i_mode,
    input  wire logic signed [gudc_pkg::COORD_W-1:0] i_point_x,
    input  wire logic signed [gudc_pkg::COORD_W-1:0] i_point_y,
    // result queue side
    output logic                                     empty,
    input  wire logic                                pop,
    output logic [1:0]                               o_status,
    output logic [7:0]                               o_cell_col,
    output logic [7:0]                               o_cell_row,
    output logic signed [gudc_pkg::COORD_W-1:0]      o_center_x,
    output logic signed [gudc_pkg::COORD_W-1:0]      o_center_y,
    output logic signed [gudc_pkg::COORD_W-1:0]      o_center_z,
    // configuration
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [gudc_pkg::ADDR_W-1:0]         paddr,
    input  wire logic [gudc_pkg::DATA_W-1:0]         pwdata,
    output logic [gudc_pkg::DATA_W-1:0]              prdata,
    output logic                                     pready
);
    localparam int CMD_W = $bits(gudc_pkg::t_cmd);
    localparam int RES_W = $bits(gudc_pkg::t_res);

    gudc_pkg::t_cfg   r_cfg;
    gudc_pkg::t_cmd   w_cmd_in, w_cmd_out;
    gudc_pkg::t_res   w_res_in, w_res_out;
    logic [CMD_W-1:0] w_cmd_q;
    logic [RES_W-1:0] w_res_q;
    logic             w_cmd_full, w_cmd_empty, w_cmd_pop;
    logic             w_res_full, w_res_push, w_init_busy;
    logic [1:0]       w_reg_idx;
    logic             w_wr;

    // register file: index from paddr[4:3], writes land in the access phase
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[4:3];
    assign w_wr      = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cell_width     <= 23'd362;
            r_cfg.inv_cell_width <= 24'd181;
            r_cfg.rsq_limit      <= 48'd65536;
            r_cfg.disk_height    <= '0;
        end else if (w_wr) begin
            case (w_reg_idx)
                gudc_pkg::REG_CELL_W: r_cfg.cell_width     <= pwdata[22:0];
                gudc_pkg::REG_INV_W:  r_cfg.inv_cell_width <= pwdata[23:0];
                gudc_pkg::REG_RSQ:    r_cfg.rsq_limit      <= pwdata[47:0];
                gudc_pkg::REG_HEIGHT: r_cfg.disk_height    <= $signed(pwdata[23:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            gudc_pkg::REG_CELL_W: prdata = 64'(r_cfg.cell_width);
            gudc_pkg::REG_INV_W:  prdata = 64'(r_cfg.inv_cell_width);
            gudc_pkg::REG_RSQ:    prdata = 64'(r_cfg.rsq_limit);
            gudc_pkg::REG_HEIGHT: prdata = 64'(r_cfg.disk_height);
            default:              prdata = '0;
        endcase
    end

    // front: cell mapping happens on the way into the command queue
    gudc_front #(.GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS)) u_front (
        .i_mode    (i_mode),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_inv     (r_cfg.inv_cell_width),
        .o_cmd     (w_cmd_in)
    );

    // no items taken while the post-reset sweep runs
    assign full = w_cmd_full || w_init_busy;

    gudc_fifo #(.W(CMD_W)) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && !w_init_busy),
        .i_data  (w_cmd_in),
        .o_full  (w_cmd_full),
        .i_pop   (w_cmd_pop),
        .o_data  (w_cmd_q),
        .o_empty (w_cmd_empty)
    );
    assign w_cmd_out = w_cmd_q;

    gudc_back #(.GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (!w_cmd_empty),
        .i_cmd       (w_cmd_out),
        .o_cmd_pop   (w_cmd_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res_in),
        .o_init_busy (w_init_busy)
    );

    gudc_fifo #(.W(RES_W)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_q),
        .o_empty (empty)
    );
    assign w_res_out = w_res_q;

    assign o_status   = w_res_out.status;
    assign o_cell_col = w_res_out.col;
    assign o_cell_row = w_res_out.row;
    assign o_center_x = w_res_out.cx;
    assign o_center_y = w_res_out.cy;
    assign o_center_z = w_res_out.cz;
endmodule
`default_nettype wire

[hw/rtl/gudc_checker.sv]
// Port-level checker for the grid unit disk cover core, bound to the top
`timescale 1ns / 1ps
`default_nettype none
`include "grid_unit_disk_cover_core_assert.svh"
module gudc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [1:0]  o_status,
    input wire logic [7:0]  o_cell_col,
    input wire logic [7:0]  o_cell_row,
    input wire logic [23:0] o_center_x,
    input wire logic [23:0] o_center_y,
    input wire logic [23:0] o_center_z
);
    logic w_no_centre, w_no_cell, w_is_out, w_is_cov, w_is_new;

    assign w_no_centre = (o_center_x == 24'd0) && (o_center_y == 24'd0) &&
                         (o_center_z == 24'd0);
    assign w_no_cell   = (o_cell_col == 8'd0) && (o_cell_row == 8'd0);
    assign w_is_out    = (o_status == gudc_pkg::ST_OUT);
    assign w_is_cov    = (o_status == gudc_pkg::ST_OWN) || (o_status == gudc_pkg::ST_NBR);
    assign w_is_new    = (o_status == gudc_pkg::ST_NEW);

    // off-grid items carry no cell and no centre
    `GUDC_ASSERT_IMP(a_out_zero, !empty && w_is_out, w_no_cell && w_no_centre)
    // covered items carry no centre
    `GUDC_ASSERT_IMP(a_cov_zero, !empty && w_is_cov, w_no_centre)
    // new disk centres are never negative in the lattice
    `GUDC_ASSERT_IMP(a_new_pos, !empty && w_is_new, !o_center_x[23] && !o_center_y[23])
    // a waiting result stays put until taken
    `GUDC_ASSERT_NXT(a_hold, !empty && !pop, !empty && $stable(o_status) && $stable(o_center_x))
endmodule

bind grid_unit_disk_cover_core gudc_checker u_gudc_checker (.*);
`default_nettype wire

[sim/tb_top.sv]
// Testbench for the grid unit disk cover core: random points checked against a local predictor
`timescale 1ns / 1ps
`default_nettype none

class cover_scoreboard;
    // predictor state
    logic [22:0] cell_w;
    logic [23:0] inv_w;
    logic [47:0] rsq;
    logic signed [23:0] height;
    bit occ [0:65535];
    // expected results, oldest first
    gudc_pkg::t_res pending_q[$];
    int mismatches;

    function new();
        cell_w = 23'd362; inv_w = 24'd181; rsq = 48'd65536; height = '0;
        foreach (occ[i]) occ[i] = 1'b0;
        mismatches = 0;
    endfunction

    function void set_reg(int idx, logic [63:0] v);
        case (idx)
            gudc_pkg::REG_CELL_W: cell_w = v[22:0];
            gudc_pkg::REG_INV_W:  inv_w = v[23:0];
            gudc_pkg::REG_RSQ:    rsq = v[47:0];
            gudc_pkg::REG_HEIGHT: height = v[23:0];
            default: ;
        endcase
    endfunction

    // floor of (coordinate * reciprocal) / 2^16
    function longint lattice_index(logic signed [23:0] p);
        longint prod;
        prod = longint'(p) * longint'({40'd0, inv_w});
        return prod >>> 16;
    endfunction

    function longint centre_of(longint idx);
        return idx * longint'(cell_w) + longint'(cell_w >> 1);
    endfunction

    function logic signed [23:0] sat24(longint v);
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return v[23:0];
    endfunction

    function longint clamp_abs(longint d);
        longint a;
        a = (d < 0) ? -d : d;
        return (a > (64'd1 << 24)) ? (64'd1 << 24) : a;
    endfunction

    function bit nbr_covers(longint px, longint py, longint c, longint r);
        longint dx, dy;
        logic [63:0] d2;
        if (c < 0 || c > 255 || r < 0 || r > 255) return 1'b0;
        if (!occ[r * 256 + c]) return 1'b0;
        dx = clamp_abs(px - centre_of(c));
        dy = clamp_abs(py - centre_of(r));
        d2 = dx * dx + dy * dy;
        return d2 <= {16'd0, rsq};
    endfunction

    // note an accepted input item
    function void note_item(bit mode, logic signed [23:0] px, logic signed [23:0] py);
        gudc_pkg::t_res r;
        longint c, w;
        if (mode) begin
            foreach (occ[i]) occ[i] = 1'b0;
            return;
        end
        r = '0;
        c = lattice_index(px);
        w = lattice_index(py);
        if (c < 0 || c > 255 || w < 0 || w > 255) begin
            r.status = gudc_pkg::ST_OUT;
        end else begin
            r.col = c[7:0]; r.row = w[7:0];
            if (occ[w * 256 + c]) begin
                r.status = gudc_pkg::ST_OWN;
            end else if (nbr_covers(px, py, c + 1, w) || nbr_covers(px, py, c - 1, w) ||
                         nbr_covers(px, py, c, w - 1) || nbr_covers(px, py, c, w + 1)) begin
                r.status = gudc_pkg::ST_NBR;
            end else begin
                r.status = gudc_pkg::ST_NEW;
                occ[w * 256 + c] = 1'b1;
                r.cx = sat24(centre_of(c));
                r.cy = sat24(centre_of(w));
                r.cz = height;
            end
        end
        pending_q = {pending_q, r};
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(gudc_pkg::t_res got);
        gudc_pkg::t_res exp_r;
        if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return;
        end
        exp_r = pending_q.pop_front();
        if (got.status !== exp_r.status || got.col !== exp_r.col || got.row !== exp_r.row ||
            got.cx !== exp_r.cx || got.cy !== exp_r.cy || got.cz !== exp_r.cz) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch exp %p got %p", exp_r, got);
        end
    endfunction
endclass

module tb_top;
    localparam int AW = gudc_pkg::ADDR_W;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic i_mode = 1'b0;
    logic signed [23:0] i_point_x = '0, i_point_y = '0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [AW-1:0] paddr = '0;
    logic [63:0] pwdata = '0;
    wire full, empty, pready;
    wire [1:0] o_status;
    wire [7:0] o_cell_col, o_cell_row;
    wire signed [23:0] o_center_x, o_center_y, o_center_z;
    wire [63:0] prdata;

    cover_scoreboard sb;
    int cycles = 0;
    bit hold_off = 1'b0;     // long receiver stall while set

    grid_unit_disk_cover_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full), .i_mode(i_mode),
        .i_point_x(i_point_x), .i_point_y(i_point_y),
        .empty(empty), .pop(pop), .o_status(o_status),
        .o_cell_col(o_cell_col), .o_cell_row(o_cell_row),
        .o_center_x(o_center_x), .o_center_y(o_center_y), .o_center_z(o_center_z),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    // watchdog: the slowest run (clears, stalls) fits far below this
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 900000) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: sample on the rising edge, change pop on the falling edge
    always @(posedge i_clk) begin
        gudc_pkg::t_res r;
        if (i_rst_n && pop && !empty) begin
            r.status = gudc_pkg::t_status'(o_status);
            r.col = o_cell_col; r.row = o_cell_row;
            r.cx = o_center_x; r.cy = o_center_y; r.cz = o_center_z;
            sb.check_result(r);
        end
    end

    // receiver stall pattern: phases of free flow and of random stalls
    initial begin
        int phase;
        phase = 0;
        forever begin
            @(negedge i_clk);
            if (phase == 0) phase = $urandom_range(1, 60) | ($urandom_range(0, 2) << 8);
            phase--;
            if (hold_off) pop <= 1'b0;
            else if (phase[8]) pop <= 1'b1;
            else pop <= ($urandom_range(0, 3) != 0);
        end
    end

    // APB write: setup cycle then access cycle
    task automatic write_reg(int idx, logic [63:0] v);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= AW'(idx * 8); pwdata <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_reg(idx, v);
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // offer one item and hold it until accepted
    task automatic send_item(bit mode, logic signed [23:0] px, logic signed [23:0] py);
        push <= 1'b1; i_mode <= mode; i_point_x <= px; i_point_y <= py;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_item(mode, px, py);
        @(negedge i_clk);
    endtask

    task automatic idle_gap(int n);
        push <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // wait until every expectation has drained, plus the clear latency
    task automatic drain();
        push <= 1'b0;
        while (sb.pending_q.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
    endtask

    // mostly in-grid points for the current cell side; some noise far outside
    task automatic random_point(output logic signed [23:0] px, output logic signed [23:0] py,
                                input int span);
        if ($urandom_range(0, 9) == 0) begin
            px = 24'($urandom); py = 24'($urandom);
        end else begin
            px = 24'($urandom_range(0, span)); py = 24'($urandom_range(0, span));
            if ($urandom_range(0, 15) == 0) px = -px;
        end
    endtask

    task automatic random_phase(int n, int span);
        int left, burst;
        logic signed [23:0] px, py;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && left > 0) begin
                random_point(px, py, span);
                if ($urandom_range(0, 99) == 0) send_item(1'b1, px, py);
                else send_item(1'b0, px, py);
                burst--; left--;
            end
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 25));
        end
    endtask

    initial begin
        int k;
        sb = new();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes of fields, clear, neighbor coverage, off-grid
        send_item(1'b0, 24'sd0, 24'sd0);
        send_item(1'b0, 24'sd0, 24'sd0);            // own cell now holds a disk
        send_item(1'b0, 24'sd400, 24'sd100);        // right of the first disk
        send_item(1'b0, 24'sd362, 24'sd0);
        send_item(1'b0, 24'sh7FFFFF, 24'sd0);       // beyond the last column
        send_item(1'b0, -24'sd1, 24'sd5);           // negative column
        send_item(1'b0, 24'sh800000, 24'sh800000);
        send_item(1'b0, 24'sd0, 24'sh7FFFFF);
        send_item(1'b0, 24'sd92000, 24'sd92000);    // next-to-last cell (index 254)
        send_item(1'b1, 24'sh7FFFFF, -24'sd1);      // clear
        send_item(1'b0, 24'sd0, 24'sd0);
        drain();

        // big cell: centre saturates, neighbor distances clamp
        write_reg(gudc_pkg::REG_CELL_W, 64'h7FFFFF);
        write_reg(gudc_pkg::REG_INV_W, 64'd1);
        write_reg(gudc_pkg::REG_RSQ, 64'hFFFF_FFFF_FFFF);
        write_reg(gudc_pkg::REG_HEIGHT, 64'h800000);
        send_item(1'b1, 24'sd0, 24'sd0);
        send_item(1'b0, 24'sh7FFFFF, 24'sh7FFFFF);
        send_item(1'b0, 24'sd0, 24'sd0);
        send_item(1'b0, 24'sd70000, 24'sd0);
        drain();

        // zero settings and maximum reciprocal
        write_reg(gudc_pkg::REG_CELL_W, 64'd0);
        write_reg(gudc_pkg::REG_INV_W, 64'hFFFFFF);
        write_reg(gudc_pkg::REG_RSQ, 64'd0);
        write_reg(gudc_pkg::REG_HEIGHT, 64'h7FFFFF);
        send_item(1'b0, 24'sd0, 24'sd0);
        send_item(1'b0, 24'sd1, 24'sd0);
        send_item(1'b0, 24'sd255, 24'sd255);
        send_item(1'b0, 24'sd256, 24'sd1);
        drain();
        write_reg(gudc_pkg::REG_INV_W, 64'd0);
        send_item(1'b0, 24'sh7FFFFF, 24'sh800000);
        drain();

        // random phases over several settings, first span covers only the low corner of the grid
        write_reg(gudc_pkg::REG_CELL_W, 64'd362);
        write_reg(gudc_pkg::REG_INV_W, 64'd181);
        write_reg(gudc_pkg::REG_RSQ, 64'd65536);
        write_reg(gudc_pkg::REG_HEIGHT, 64'd1234);
        send_item(1'b1, 24'sd0, 24'sd0);
        random_phase(250, 8000);

        // long receiver hold-off while the sender keeps offering
        fork
            begin
                hold_off = 1'b1;
                k = 0;
                while (k < 400) begin
                    @(negedge i_clk);
                    k++;
                end
                hold_off = 1'b0;
            end
            random_phase(40, 8000);
        join
        drain();

        for (k = 0; k < 3; k++) begin
            write_reg(gudc_pkg::REG_CELL_W, 64'($urandom_range(20, 1000)));
            write_reg(gudc_pkg::REG_INV_W, 64'(65536 / sb.cell_w));
            write_reg(gudc_pkg::REG_RSQ, {$urandom, $urandom} & 64'hFFFFFFFFFFFF
                                         >> $urandom_range(16, 47));
            write_reg(gudc_pkg::REG_HEIGHT, 64'($urandom));
            send_item(1'b1, 24'sd0, 24'sd0);
            random_phase(200, sb.cell_w * $urandom_range(4, 300));
            drain();
        end

        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
